// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and disabled
// while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(LBL, CLK, RSTN, ANT, CON) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANT) |-> (CON)) \
        else $error("same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(LBL, CLK, RSTN, ANT, CON) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANT) |=> (CON)) \
        else $error("next-cycle implication failed");

`endif

// ===== sv/bmpu_pkg.sv =====
// ----------------------------------------------------------------------------
// BMP icon upscaler package
// Widths, result codes and the pixel burst record shared by the upscaler.
// ----------------------------------------------------------------------------
package bmpu_pkg;

    localparam int SRC_SIZE_DEFAULT = 40;
    localparam int DST_SIZE_DEFAULT = 70;

    localparam int BYTE_W   = 8;
    localparam int ORIGIN_W = 9;
    localparam int COORD_W  = 10;
    localparam int COLOR_W  = 16;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 1;

    localparam logic [STATUS_W-1:0] STAT_PIXEL      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_BAD_SIG    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BAD_SIZE   = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_BAD_OFFSET = 2'd3;

    localparam logic [INDEX_W-1:0] REG_ORIGIN_X = 1'd0;
    localparam logic [INDEX_W-1:0] REG_ORIGIN_Y = 1'd1;

    typedef struct packed {
        logic [COORD_W-1:0]  base_x;
        logic [COORD_W-1:0]  base_y;
        logic [COLOR_W-1:0]  color;
        logic [STATUS_W-1:0] status;
        logic                nx_m1;
        logic                ny_m1;
    } burst_t;

endpackage

// ===== sv/bmpu_byte_if.sv =====
// ----------------------------------------------------------------------------
// File byte channel
// Carries one byte of the bitmap file per request, with a start-of-file mark.
// ----------------------------------------------------------------------------
interface bmpu_byte_if import bmpu_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] file_byte;
    logic              start_of_file;

    modport source (output valid, output file_byte, output start_of_file, input ready);
    modport sink (input valid, input file_byte, input start_of_file, output ready);

endinterface

// ===== sv/bmpu_pix_if.sv =====
// ----------------------------------------------------------------------------
// Pixel write channel
// Carries one pixel write or header status per request.
// ----------------------------------------------------------------------------
interface bmpu_pix_if import bmpu_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [COORD_W-1:0]  pixel_x;
    logic [COORD_W-1:0]  pixel_y;
    logic [COLOR_W-1:0]  color;
    logic [STATUS_W-1:0] status;
    logic                last;

    modport source (output valid, output pixel_x, output pixel_y, output color,
                    output status, output last, input ready);
    modport sink (input valid, input pixel_x, input pixel_y, input color,
                  input status, input last, output ready);

endinterface

// ===== sv/bmpu_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries a register index and its write data per request.
// ----------------------------------------------------------------------------
interface bmpu_cfg_if import bmpu_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [INDEX_W-1:0]  index;
    logic [ORIGIN_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);

endinterface

// ===== sv/bmpu_emit.sv =====
// ----------------------------------------------------------------------------
// Pixel burst emitter
// Holds one burst of up to two by two pixel writes and presents them in turn,
// column outer and row inner, through a registered output.
// ----------------------------------------------------------------------------
module bmpu_emit import bmpu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  burst_t       burst,
    output logic         load_ready,
    bmpu_pix_if.source   dst
);

    logic                busy_reg;
    burst_t              burst_reg;
    logic                dx_reg;
    logic                dy_reg;
    logic                out_valid_reg;
    logic [COORD_W-1:0]  x_reg;
    logic [COORD_W-1:0]  y_reg;
    logic [COLOR_W-1:0]  color_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                last_reg;
    logic                out_free;
    logic                advance;
    logic                at_end;

    assign out_free   = !out_valid_reg || dst.ready;
    assign advance    = busy_reg && out_free;
    assign at_end     = (dx_reg == burst_reg.nx_m1) && (dy_reg == burst_reg.ny_m1);
    assign load_ready = !busy_reg || (advance && at_end);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            dx_reg        <= 1'b0;
            dy_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                busy_reg <= 1'b1;
                dx_reg   <= 1'b0;
                dy_reg   <= 1'b0;
            end
            else if (advance)
            begin
                if (at_end)
                begin
                    busy_reg <= 1'b0;
                end
                else if (dy_reg == burst_reg.ny_m1)
                begin
                    dy_reg <= 1'b0;
                    dx_reg <= 1'b1;
                end
                else
                begin
                    dy_reg <= 1'b1;
                end
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (dst.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            burst_reg <= burst;
        end
        if (advance)
        begin
            x_reg      <= burst_reg.base_x + COORD_W'(dx_reg);
            y_reg      <= burst_reg.base_y + COORD_W'(dy_reg);
            color_reg  <= burst_reg.color;
            status_reg <= burst_reg.status;
            last_reg   <= at_end;
        end
    end

    assign dst.valid   = out_valid_reg;
    assign dst.pixel_x = x_reg;
    assign dst.pixel_y = y_reg;
    assign dst.color   = color_reg;
    assign dst.status  = status_reg;
    assign dst.last    = last_reg;

endmodule

// ===== sv/bmp_icon_nearest_upscaler.sv =====
// ----------------------------------------------------------------------------
// BMP icon nearest-neighbour upscaler: byte parser, RGB565 packer and scaler.
// A byte is taken every cycle while it gives at most one write and dst is ready;
// one giving more writes holds the next byte until its last write goes from the
// burst register to the lone output register. Reset clears parse state, origin.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bmp_icon_nearest_upscaler import bmpu_pkg::*;
#(
    parameter int SRC_SIZE = SRC_SIZE_DEFAULT,
    parameter int DST_SIZE = DST_SIZE_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    bmpu_byte_if.sink  src,
    bmpu_pix_if.source dst,
    bmpu_cfg_if.sink   cfg
);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_SKIP   = 2'd1;
    localparam logic [1:0] PH_PIXELS = 2'd2;
    localparam logic [1:0] PH_IDLE   = 2'd3;

    localparam logic [1:0] TRIP_BLUE  = 2'd0;
    localparam logic [1:0] TRIP_GREEN = 2'd1;
    localparam logic [1:0] TRIP_RED   = 2'd2;

    localparam int HDR_LEN        = 54;
    localparam int HDR_OFFSET_POS = 10;
    localparam int HDR_WIDTH_POS  = 18;
    localparam int HDR_HEIGHT_POS = 22;
    localparam int POS_W          = 6;
    localparam int SPAN_DEPTH     = 2 ** POS_W;
    localparam int SPAN_W         = 8;

    localparam logic [POS_W-1:0]  HDR_SIG0_POS = 6'd0;
    localparam logic [POS_W-1:0]  HDR_SIG1_POS = 6'd1;
    localparam logic [POS_W-1:0]  HDR_LAST_POS = POS_W'(HDR_LEN - 1);
    localparam logic [BYTE_W-1:0] ASCII_B      = 8'h42;
    localparam logic [BYTE_W-1:0] ASCII_M      = 8'h4D;

    logic [SPAN_W-1:0] span_lut [SPAN_DEPTH];

    for (genvar g = 0; g < SPAN_DEPTH; g++)
    begin : g_span
        localparam int SpanValue = (g * DST_SIZE) / SRC_SIZE;
        assign span_lut[g] = SPAN_W'(SpanValue);
    end

    logic [1:0]          phase_reg,       phase_next;
    logic [31:0]         byte_count_reg,  byte_count_next;
    logic                sig_good_reg,    sig_good_next;
    logic [31:0]         img_width_reg,   img_width_next;
    logic [31:0]         img_height_reg,  img_height_next;
    logic [31:0]         data_offset_reg, data_offset_next;
    logic [1:0]          triplet_reg,     triplet_next;
    logic [BYTE_W-1:0]   blue_reg,        blue_next;
    logic [BYTE_W-1:0]   green_reg,       green_next;
    logic [POS_W-1:0]    src_col_reg,     src_col_next;
    logic [POS_W-1:0]    src_row_reg,     src_row_next;
    logic [ORIGIN_W-1:0] origin_x_reg;
    logic [ORIGIN_W-1:0] origin_y_reg;

    logic                accept;
    logic                sof;
    logic [BYTE_W-1:0]   b;
    logic [1:0]          cur_phase;
    logic [31:0]         pos;
    logic [POS_W-1:0]    hdr_pos;
    logic [1:0]          lane;
    logic [POS_W-1:0]    cur_col;
    logic [POS_W-1:0]    cur_row;
    logic [POS_W-1:0]    flip_row;
    logic [SPAN_W-1:0]   xs, xe, ys, ye, x_len, y_len;
    logic                do_pixel;
    logic                gen;
    burst_t              burst_next;
    logic                burst_load;
    logic                load_ready;

    assign accept = src.valid && src.ready;
    assign sof    = src.start_of_file;
    assign b      = src.file_byte;

    assign cur_phase = sof ? PH_HEADER : phase_reg;
    assign pos       = sof ? 32'd0 : byte_count_reg;
    assign hdr_pos   = pos[POS_W-1:0];
    assign lane      = 2'(hdr_pos - POS_W'(HDR_OFFSET_POS));
    assign cur_col   = sof ? '0 : src_col_reg;
    assign cur_row   = sof ? '0 : src_row_reg;
    assign flip_row  = POS_W'(SRC_SIZE - 1) - cur_row;

    assign xs    = span_lut[cur_col];
    assign xe    = span_lut[POS_W'(cur_col + 1'b1)];
    assign ys    = span_lut[flip_row];
    assign ye    = span_lut[POS_W'(flip_row + 1'b1)];
    assign x_len = xe - xs;
    assign y_len = ye - ys;

    always_comb
    begin
        phase_next       = cur_phase;
        byte_count_next  = pos + 32'd1;
        sig_good_next    = sof ? 1'b0 : sig_good_reg;
        img_width_next   = sof ? 32'd0 : img_width_reg;
        img_height_next  = sof ? 32'd0 : img_height_reg;
        data_offset_next = sof ? 32'd0 : data_offset_reg;
        triplet_next     = sof ? TRIP_BLUE : triplet_reg;
        blue_next        = sof ? 8'd0 : blue_reg;
        green_next       = sof ? 8'd0 : green_reg;
        src_col_next     = cur_col;
        src_row_next     = cur_row;
        do_pixel         = 1'b0;
        gen              = 1'b0;
        burst_next       = '0;

        unique case (cur_phase)
            PH_HEADER:
            begin
                case (hdr_pos) inside
                    HDR_SIG0_POS:
                        sig_good_next = (b == ASCII_B);
                    HDR_SIG1_POS:
                        sig_good_next = sig_good_next && (b == ASCII_M);
                    [POS_W'(HDR_OFFSET_POS):POS_W'(HDR_OFFSET_POS + 3)]:
                        data_offset_next[8*lane +: 8] = b;
                    [POS_W'(HDR_WIDTH_POS):POS_W'(HDR_WIDTH_POS + 3)]:
                        img_width_next[8*lane +: 8] = b;
                    [POS_W'(HDR_HEIGHT_POS):POS_W'(HDR_HEIGHT_POS + 3)]:
                        img_height_next[8*lane +: 8] = b;
                    default:
                    begin
                    end
                endcase

                if (hdr_pos == HDR_LAST_POS)
                begin
                    if (!sig_good_next)
                    begin
                        gen               = 1'b1;
                        burst_next.status = STAT_BAD_SIG;
                        phase_next        = PH_IDLE;
                    end
                    else if (img_width_next != 32'(SRC_SIZE) ||
                             img_height_next != 32'(SRC_SIZE))
                    begin
                        gen               = 1'b1;
                        burst_next.status = STAT_BAD_SIZE;
                        phase_next        = PH_IDLE;
                    end
                    else if (data_offset_next < 32'(HDR_LEN))
                    begin
                        gen               = 1'b1;
                        burst_next.status = STAT_BAD_OFFSET;
                        phase_next        = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = (data_offset_next == 32'(HDR_LEN)) ? PH_PIXELS : PH_SKIP;
                    end
                end
            end
            PH_SKIP:
            begin
                if (pos == data_offset_next)
                begin
                    phase_next = PH_PIXELS;
                    do_pixel   = 1'b1;
                end
            end
            PH_PIXELS:
                do_pixel = 1'b1;
            default:
            begin
            end
        endcase

        if (do_pixel)
        begin
            unique case (triplet_next)
                TRIP_BLUE:
                begin
                    blue_next    = b;
                    triplet_next = TRIP_GREEN;
                end
                TRIP_GREEN:
                begin
                    green_next   = b;
                    triplet_next = TRIP_RED;
                end
                default:
                begin
                    triplet_next      = TRIP_BLUE;
                    gen               = (x_len != '0) && (y_len != '0);
                    burst_next.base_x = COORD_W'(origin_x_reg) + COORD_W'(xs);
                    burst_next.base_y = COORD_W'(origin_y_reg) + COORD_W'(ys);
                    burst_next.color  = {b[7:3], green_next[7:2], blue_next[7:3]};
                    burst_next.status = STAT_PIXEL;
                    burst_next.nx_m1  = (x_len >= 8'd2);
                    burst_next.ny_m1  = (y_len >= 8'd2);

                    if (POS_W'(cur_col + 1'b1) >= POS_W'(SRC_SIZE))
                    begin
                        src_col_next = '0;
                        if (POS_W'(cur_row + 1'b1) >= POS_W'(SRC_SIZE))
                        begin
                            src_row_next = '0;
                            phase_next   = PH_IDLE;
                        end
                        else
                        begin
                            src_row_next = POS_W'(cur_row + 1'b1);
                        end
                    end
                    else
                    begin
                        src_col_next = POS_W'(cur_col + 1'b1);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HEADER;
            byte_count_reg  <= '0;
            sig_good_reg    <= 1'b0;
            img_width_reg   <= '0;
            img_height_reg  <= '0;
            data_offset_reg <= '0;
            triplet_reg     <= TRIP_BLUE;
            blue_reg        <= '0;
            green_reg       <= '0;
            src_col_reg     <= '0;
            src_row_reg     <= '0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            byte_count_reg  <= byte_count_next;
            sig_good_reg    <= sig_good_next;
            img_width_reg   <= img_width_next;
            img_height_reg  <= img_height_next;
            data_offset_reg <= data_offset_next;
            triplet_reg     <= triplet_next;
            blue_reg        <= blue_next;
            green_reg       <= green_next;
            src_col_reg     <= src_col_next;
            src_row_reg     <= src_row_next;
        end
    end

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_ORIGIN_X: origin_x_reg <= cfg.data;
                REG_ORIGIN_Y: origin_y_reg <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    assign burst_load = accept && gen;
    assign src.ready  = load_ready;

    bmpu_emit u_emit
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (burst_load),
        .burst      (burst_next),
        .load_ready (load_ready),
        .dst        (dst)
    );

    `ASSERT_IMPL(a_header_window, clk, rst_n, phase_reg == PH_HEADER, byte_count_reg < 32'(HDR_LEN))
    `ASSERT_NEXT(a_fail_goes_idle, clk, rst_n, burst_load && burst_next.status != STAT_PIXEL, phase_reg == PH_IDLE)
    `ASSERT_IMPL(a_status_is_last, clk, rst_n, dst.valid && dst.status != STAT_PIXEL, dst.last)

endmodule

// ===== bench/bmp_icon_nearest_upscaler_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP icon upscaler pixel write checker
// Watches the byte, pixel and configuration channels. From every accepted
// byte it works out the pixel writes and header verdicts the upscaler should
// give, and compares each accepted result with the oldest one still waiting.
// ----------------------------------------------------------------------------
module bmp_icon_nearest_upscaler_checker import bmpu_pkg::*;
#(
    parameter int SRC_SIZE = SRC_SIZE_DEFAULT,
    parameter int DST_SIZE = DST_SIZE_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    bmpu_byte_if src,
    bmpu_pix_if  dst,
    bmpu_cfg_if  cfg,
    output int   pending,
    output int   failures
);

    localparam int         HEADER_LEN  = 54;
    localparam int         VERDICT_POS = HEADER_LEN - 1;
    localparam int         OFFSET_POS  = 10;
    localparam int         WIDTH_POS   = 18;
    localparam int         HEIGHT_POS  = 22;
    localparam int         FIELD_BYTES = 4;
    localparam int         MAX_SPAN    = 2;
    localparam int         MAX_REPORTS = 10;
    localparam logic [7:0] SIG_FIRST   = "B";
    localparam logic [7:0] SIG_SECOND  = "M";

    typedef enum logic [1:0] {
        PARSE_HEADER,
        PARSE_SKIP,
        PARSE_PIXELS,
        PARSE_DONE
    } parse_phase_e;

    typedef enum logic [1:0] {
        SLOT_BLUE,
        SLOT_GREEN,
        SLOT_RED
    } colour_slot_e;

    typedef struct packed {
        logic [COORD_W-1:0]  pixel_x;
        logic [COORD_W-1:0]  pixel_y;
        logic [COLOR_W-1:0]  color;
        logic [STATUS_W-1:0] status;
        logic                last;
    } pixel_write_t;

    parse_phase_e        phase;
    colour_slot_e        colour_slot;
    logic [31:0]         file_pos;
    logic                sig_ok;
    logic [31:0]         width_field;
    logic [31:0]         height_field;
    logic [31:0]         offset_field;
    logic [7:0]          blue_byte;
    logic [7:0]          green_byte;
    int                  src_col;
    int                  src_row;
    logic [ORIGIN_W-1:0] org_x;
    logic [ORIGIN_W-1:0] org_y;
    pixel_write_t        writes_q[$];
    int                  fail_count;

    function automatic int span_start(input int i);
        return (i * DST_SIZE) / SRC_SIZE;
    endfunction

    task automatic restart_parse();
        phase        = PARSE_HEADER;
        colour_slot  = SLOT_BLUE;
        file_pos     = '0;
        sig_ok       = 1'b0;
        width_field  = '0;
        height_field = '0;
        offset_field = '0;
        blue_byte    = '0;
        green_byte   = '0;
        src_col      = 0;
        src_row      = 0;
    endtask

    task automatic take_pixel_byte(input logic [7:0] b);
        pixel_write_t w;
        int           row;
        int           xs;
        int           ys;
        int           nx;
        int           ny;
        int           coord;
        if (colour_slot == SLOT_BLUE) begin
            blue_byte   = b;
            colour_slot = SLOT_GREEN;
        end
        else if (colour_slot == SLOT_GREEN) begin
            green_byte  = b;
            colour_slot = SLOT_RED;
        end
        else begin
            colour_slot = SLOT_BLUE;
            // Bitmap rows arrive bottom row first.
            row = SRC_SIZE - 1 - src_row;
            xs  = span_start(src_col);
            ys  = span_start(row);
            nx  = span_start(src_col + 1) - xs;
            ny  = span_start(row + 1) - ys;
            if (nx > MAX_SPAN)
                nx = MAX_SPAN;
            if (ny > MAX_SPAN)
                ny = MAX_SPAN;
            for (int dx = 0; dx < nx; dx++)
            begin
                for (int dy = 0; dy < ny; dy++)
                begin
                    w           = '0;
                    coord       = int'(org_x) + xs + dx;
                    w.pixel_x   = coord[COORD_W-1:0];
                    coord       = int'(org_y) + ys + dy;
                    w.pixel_y   = coord[COORD_W-1:0];
                    w.color     = {b[7:3], green_byte[7:2], blue_byte[7:3]};
                    w.status    = STAT_PIXEL;
                    w.last      = (dx == nx - 1) && (dy == ny - 1);
                    writes_q.push_back(w);
                end
            end
            src_col++;
            if (src_col >= SRC_SIZE) begin
                src_col = 0;
                src_row++;
                if (src_row >= SRC_SIZE) begin
                    src_row = 0;
                    phase   = PARSE_DONE;
                end
            end
        end
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic sof);
        pixel_write_t w;
        logic [31:0]  pos;
        if (sof)
            restart_parse();
        pos = file_pos;
        case (phase)
            PARSE_HEADER:
            begin
                if (pos == 0)
                    sig_ok = (b == SIG_FIRST);
                else if (pos == 1)
                    sig_ok = sig_ok && (b == SIG_SECOND);
                else if (pos >= OFFSET_POS && pos < OFFSET_POS + FIELD_BYTES)
                    offset_field |= {24'd0, b} << (8 * (pos - OFFSET_POS));
                else if (pos >= WIDTH_POS && pos < WIDTH_POS + FIELD_BYTES)
                    width_field |= {24'd0, b} << (8 * (pos - WIDTH_POS));
                else if (pos >= HEIGHT_POS && pos < HEIGHT_POS + FIELD_BYTES)
                    height_field |= {24'd0, b} << (8 * (pos - HEIGHT_POS));
                if (pos == VERDICT_POS) begin
                    w      = '0;
                    w.last = 1'b1;
                    if (!sig_ok)
                        w.status = STAT_BAD_SIG;
                    else if (width_field != SRC_SIZE || height_field != SRC_SIZE)
                        w.status = STAT_BAD_SIZE;
                    else if (offset_field < HEADER_LEN)
                        w.status = STAT_BAD_OFFSET;
                    if (w.status != STAT_PIXEL) begin
                        writes_q.push_back(w);
                        phase = PARSE_DONE;
                    end
                    else if (offset_field == HEADER_LEN)
                        phase = PARSE_PIXELS;
                    else
                        phase = PARSE_SKIP;
                end
            end
            PARSE_SKIP:
            begin
                if (pos == offset_field) begin
                    phase = PARSE_PIXELS;
                    take_pixel_byte(b);
                end
            end
            PARSE_PIXELS:
                take_pixel_byte(b);
            default:
                ;
        endcase
        file_pos = pos + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pixel_write_t got;
        pixel_write_t want;
        if (!rst_n) begin
            restart_parse();
            org_x = '0;
            org_y = '0;
            writes_q.delete();
            fail_count = 0;
            pending  <= 0;
            failures <= 0;
        end
        else begin
            if (dst.valid && dst.ready) begin
                got = {dst.pixel_x, dst.pixel_y, dst.color, dst.status, dst.last};
                if (writes_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: unexpected request x=%0d y=%0d color=%h status=%0d last=%0d",
                                 $realtime, got.pixel_x, got.pixel_y, got.color,
                                 got.status, got.last);
                end
                else begin
                    want = writes_q.pop_front();
                    if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
                        got.color !== want.color || got.status !== want.status ||
                        got.last !== want.last) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("%0t: mismatch expected x=%0d y=%0d color=%h status=%0d last=%0d",
                                     $realtime, want.pixel_x, want.pixel_y, want.color,
                                     want.status, want.last,
                                     "\n    got x=%0d y=%0d color=%h status=%0d last=%0d",
                                     got.pixel_x, got.pixel_y, got.color, got.status,
                                     got.last);
                    end
                end
            end
            if (cfg.valid && cfg.ready) begin
                if (cfg.index == REG_ORIGIN_X)
                    org_x = cfg.data;
                else if (cfg.index == REG_ORIGIN_Y)
                    org_y = cfg.data;
            end
            if (src.valid && src.ready)
                predict_byte(src.file_byte, src.start_of_file);
            pending  <= writes_q.size();
            failures <= fail_count;
        end
    end

endmodule

// ===== bench/bmp_icon_nearest_upscaler_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP icon upscaler testbench
// Streams bitmap files into the upscaler a byte per request: broken, truncated
// and interrupted headers, skipped offsets and short images, with origin
// changes between files and random idling on both channels.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module bmp_icon_nearest_upscaler_tb;
    import bmpu_pkg::*;

    localparam int                  SRC            = SRC_SIZE_DEFAULT;
    localparam int                  DST            = DST_SIZE_DEFAULT;
    localparam int                  HEADER_LEN     = 54;
    localparam int                  OFFSET_POS     = 10;
    localparam int                  WIDTH_POS      = 18;
    localparam int                  HEIGHT_POS     = 22;
    localparam int                  FIELD_BYTES    = 4;
    localparam int                  SKIP_MAX       = 400;
    localparam int                  PIXEL_BYTES    = 3;
    localparam logic [7:0]          SIG_FIRST      = "B";
    localparam logic [7:0]          SIG_SECOND     = "M";
    localparam int                  DRAIN_CYCLES   = 8;
    localparam int                  WATCHDOG_LIMIT = 2000;
    localparam int                  RANDOM_FILES   = 2;
    localparam int                  QUIET_FILES    = 1;
    localparam logic [ORIGIN_W-1:0] ORIGIN_MAX     = '1;

    logic       clk;
    logic       rst_n;
    int         pending;
    int         failures;
    bit         quiet;
    int         idle_cycles;
    int         kind;
    int         pos;
    logic [7:0] file_q[$];

    bmpu_byte_if byte_ch();
    bmpu_pix_if  pix_ch();
    bmpu_cfg_if  cfg_ch();

    bmp_icon_nearest_upscaler #(
        .SRC_SIZE(SRC),
        .DST_SIZE(DST)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .src(byte_ch),
        .dst(pix_ch),
        .cfg(cfg_ch)
    );

    bmp_icon_nearest_upscaler_checker #(
        .SRC_SIZE(SRC),
        .DST_SIZE(DST)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .src(byte_ch),
        .dst(pix_ch),
        .cfg(cfg_ch),
        .pending(pending),
        .failures(failures)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic send_byte(input logic [7:0] b, input logic sof);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        byte_ch.valid         <= 1'b1;
        byte_ch.file_byte     <= b;
        byte_ch.start_of_file <= sof;
        @(posedge clk);
        while (!byte_ch.ready) @(posedge clk);
    endtask

    task automatic send_file(input bit marked, input int count);
        for (int i = 0; i < count && i < file_q.size(); i++)
            send_byte(file_q[i], marked && (i == 0));
    endtask

    task automatic make_header(input logic [7:0] s0, input logic [7:0] s1,
                               input logic [31:0] w, input logic [31:0] h,
                               input logic [31:0] off);
        logic [7:0] hb;
        file_q.delete();
        for (int i = 0; i < HEADER_LEN; i++) begin
            hb = 8'($urandom);
            if (i == 0)
                hb = s0;
            else if (i == 1)
                hb = s1;
            else if (i >= OFFSET_POS && i < OFFSET_POS + FIELD_BYTES)
                hb = off[8 * (i - OFFSET_POS) +: 8];
            else if (i >= WIDTH_POS && i < WIDTH_POS + FIELD_BYTES)
                hb = w[8 * (i - WIDTH_POS) +: 8];
            else if (i >= HEIGHT_POS && i < HEIGHT_POS + FIELD_BYTES)
                hb = h[8 * (i - HEIGHT_POS) +: 8];
            file_q.push_back(hb);
        end
        if (off > HEADER_LEN && off <= SKIP_MAX)
            repeat (off - HEADER_LEN) file_q.push_back(8'($urandom));
    endtask

    task automatic add_pixels(input int n);
        repeat (n * PIXEL_BYTES) file_q.push_back(8'($urandom));
    endtask

    task automatic good_file(input logic [31:0] off, input int n);
        make_header(SIG_FIRST, SIG_SECOND, SRC, SRC, off);
        add_pixels(n);
    endtask

    // Waits until every predicted request has arrived and the pipeline is empty.
    task automatic wait_idle();
        byte_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [ORIGIN_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        pix_ch.ready = 1'b0;
        @(posedge clk);
        forever begin
            if (!quiet && $urandom_range(0, 5) == 0) begin
                pix_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            pix_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (byte_ch.valid && byte_ch.ready) || (pix_ch.valid && pix_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        logic [ORIGIN_W-1:0] val;
        rst_n                 = 1'b0;
        quiet                 = 1'b0;
        byte_ch.valid         = 1'b0;
        byte_ch.file_byte     = '0;
        byte_ch.start_of_file = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = REG_ORIGIN_X;
        cfg_ch.data           = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Straight after reset the block parses without a start-of-file mark.
        good_file(HEADER_LEN, 4);
        send_file(1'b0, file_q.size());

        // A new file cuts into a header part way through.
        good_file(HEADER_LEN + 3, 2);
        send_file(1'b1, 20);

        // Origin at its top end; the coordinates still fit in the pixel fields without wrap.
        wait_idle();
        write_reg(REG_ORIGIN_X, ORIGIN_MAX);
        write_reg(REG_ORIGIN_Y, ORIGIN_MAX);

        for (int f = 0; f < RANDOM_FILES; f++)
        begin
            if (f >= RANDOM_FILES - QUIET_FILES)
                quiet = 1'b1;
            if (f > 0 && $urandom_range(0, 1) == 0)
            begin
                wait_idle();
                if ($urandom_range(0, 2) == 0)
                    val = $urandom_range(0, 1) ? ORIGIN_MAX : '0;
                else
                    val = ORIGIN_W'($urandom_range(0, 511));
                write_reg($urandom_range(0, 1) ? REG_ORIGIN_Y : REG_ORIGIN_X, val);
            end
            kind = $urandom_range(0, 4);
            if (kind == 0)
            begin
                make_header("A", SIG_SECOND, SRC, SRC, HEADER_LEN);
                add_pixels(1);
            end
            else if (kind == 1)
                make_header(SIG_FIRST, SIG_SECOND, SRC, 32'hFFFF_FFD8, HEADER_LEN);
            else if (kind == 2)
            begin
                make_header(SIG_FIRST, SIG_SECOND, SRC, SRC, HEADER_LEN - 1);
                add_pixels(1);
            end
            else if (kind == 3)
            begin
                good_file(HEADER_LEN + $urandom_range(0, 3), $urandom_range(1, 4));
                pos = $urandom_range(0, 9);
                if (pos >= 6)
                    pos = WIDTH_POS + $urandom_range(0, 2 * FIELD_BYTES - 1);
                else if (pos >= 2)
                    pos = OFFSET_POS + pos - 2;
                file_q[pos] = 8'($urandom);
            end
            else
                good_file(HEADER_LEN + $urandom_range(0, 3), $urandom_range(2, 5));
            send_file(1'b1, file_q.size());
        end

        repeat ($urandom_range(8, 16))
            send_byte(8'($urandom), $urandom_range(0, 3) == 0);

        wait_idle();
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/bmpu_pkg.sv
sv/bmpu_byte_if.sv
sv/bmpu_pix_if.sv
sv/bmpu_cfg_if.sv
sv/bmpu_emit.sv
sv/bmp_icon_nearest_upscaler.sv
bench/bmp_icon_nearest_upscaler_checker.sv
bench/bmp_icon_nearest_upscaler_tb.sv
